// ----- src/tod_pkg.sv -----
// tod_pkg: command codes, limits and digit helpers for the time-of-day display
// used by time_of_day_clock_display; no dependencies
package tod_pkg;

	localparam int unsigned HourW = 5;
	localparam int unsigned UnitW = 6;
	localparam int unsigned ReqW  = 4;

	localparam logic [UnitW-1:0] UNIT_MAX = 6'd59;
	localparam logic [HourW-1:0] HOUR_MAX = 5'd23;
	localparam logic [HourW-1:0] HALF_DAY = 5'd12;
	localparam logic [7:0]       ASCII_ZERO = 8'd48;

	typedef enum logic [ReqW-1:0] {
		REQ_INC_SEC = 4'd0,
		REQ_INC_MIN = 4'd1,
		REQ_INC_HR  = 4'd2,
		REQ_DEC_SEC = 4'd3,
		REQ_DEC_MIN = 4'd4,
		REQ_DEC_HR  = 4'd5,
		REQ_SET_SEC = 4'd6,
		REQ_SET_MIN = 4'd7,
		REQ_SET_HR  = 4'd8,
		REQ_READ    = 4'd9
	} req_t;

	// tens digit of a value below 60
	function automatic logic [2:0] tens_of(input logic [UnitW-1:0] v);
		logic [2:0] t;
		if (v >= 6'd50)      t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else                 t = 3'd0;
		return t;
	endfunction

	// two ascii digits of a value below 60
	function automatic logic [15:0] two_digits(input logic [UnitW-1:0] v);
		logic [2:0]       t;
		logic [UnitW-1:0] ones;
		t    = tens_of(v);
		ones = v - UnitW'({t, 3'b000} + {2'b00, t, 1'b0});
		return {ASCII_ZERO + 8'(t), ASCII_ZERO + 8'(ones)};
	endfunction

endpackage

// ----- src/time_of_day_clock_display.sv -----
// time_of_day_clock_display: hh:mm:ss counters with 12/24-hour ascii display line
// depends on tod_pkg
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_stall  | req_type, set_value, alarm_on
//  out      | out_valid/out_stall| hours_now, minutes_now, seconds_now, text_*
//  cfg      | cfg_wr_en          | cfg_wr_data (twelve_hour_mode)
//
// one beat per cycle while out_stall is low; a beat is held in the input register
// and then moves on to the result register; out_valid rises as the beat enters there
// the time update and text formatting run in one pass between the two registers
// reset clears the time to 00:00:00, 24-hour form, both registers empty
// out_stall holds the result register; the input register still takes one more beat
module time_of_day_clock_display (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tod_pkg::ReqW-1:0]   req_type,
	input  logic [tod_pkg::UnitW-1:0]  set_value,
	input  logic                       alarm_on,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tod_pkg::HourW-1:0]  hours_now,
	output logic [tod_pkg::UnitW-1:0]  minutes_now,
	output logic [tod_pkg::UnitW-1:0]  seconds_now,
	output logic [63:0]                text_left,
	output logic [63:0]                text_right
);
	import tod_pkg::*;

	logic             twelve_q;
	logic [HourW-1:0] hour_q;
	logic [UnitW-1:0] min_q;
	logic [UnitW-1:0] sec_q;

	logic             valid_s1;
	logic [ReqW-1:0]  req_s1;
	logic [UnitW-1:0] val_s1;
	logic             alarm_s1;

	logic             out_free;
	logic             advance;
	logic             take_in;

	logic [HourW-1:0] hour_n;
	logic [UnitW-1:0] min_n;
	logic [UnitW-1:0] sec_n;
	logic [HourW-1:0] shown;
	logic [15:0]      hh_txt;
	logic [15:0]      mm_txt;
	logic [15:0]      ss_txt;
	logic [15:0]      ampm_txt;
	logic [15:0]      alarm_txt;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	// next time value
	always_comb begin
		hour_n = hour_q;
		min_n  = min_q;
		sec_n  = sec_q;
		case (req_t'(req_s1))
			REQ_INC_SEC: begin
				if (sec_q == UNIT_MAX) begin
					sec_n = '0;
					if (min_q == UNIT_MAX) begin
						min_n  = '0;
						hour_n = (hour_q == HOUR_MAX) ? '0 : hour_q + 1'b1;
					end else begin
						min_n = min_q + 1'b1;
					end
				end else begin
					sec_n = sec_q + 1'b1;
				end
			end
			REQ_INC_MIN: begin
				if (min_q == UNIT_MAX) begin
					min_n  = '0;
					hour_n = (hour_q == HOUR_MAX) ? '0 : hour_q + 1'b1;
				end else begin
					min_n = min_q + 1'b1;
				end
			end
			REQ_INC_HR: hour_n = (hour_q == HOUR_MAX) ? '0 : hour_q + 1'b1;
			REQ_DEC_SEC: begin
				if (sec_q == '0) begin
					sec_n = UNIT_MAX;
					if (min_q == '0) begin
						min_n  = UNIT_MAX;
						hour_n = (hour_q == '0) ? '0 : hour_q - 1'b1;
					end else begin
						min_n = min_q - 1'b1;
					end
				end else begin
					sec_n = sec_q - 1'b1;
				end
			end
			REQ_DEC_MIN: begin
				if (min_q == '0) begin
					min_n  = UNIT_MAX;
					hour_n = (hour_q == '0) ? '0 : hour_q - 1'b1;
				end else begin
					min_n = min_q - 1'b1;
				end
			end
			REQ_DEC_HR:  hour_n = (hour_q == '0) ? '0 : hour_q - 1'b1;
			REQ_SET_SEC: sec_n = (val_s1 > UNIT_MAX) ? UNIT_MAX : val_s1;
			REQ_SET_MIN: min_n = (val_s1 > UNIT_MAX) ? UNIT_MAX : val_s1;
			REQ_SET_HR:  hour_n = (val_s1 > UnitW'(HOUR_MAX)) ? HOUR_MAX : val_s1[HourW-1:0];
			default: ;
		endcase
	end

	// display text
	always_comb begin
		if (!twelve_q)                shown = hour_n;
		else if (hour_n == '0)        shown = HALF_DAY;
		else if (hour_n > HALF_DAY)   shown = hour_n - HALF_DAY;
		else                          shown = hour_n;
		hh_txt    = two_digits(UnitW'(shown));
		mm_txt    = two_digits(min_n);
		ss_txt    = two_digits(sec_n);
		ampm_txt  = !twelve_q ? "  " : ((hour_n >= HALF_DAY) ? "PM" : "AM");
		alarm_txt = alarm_s1 ? "N " : "FF";
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			twelve_q  <= 1'b0;
			hour_q    <= '0;
			min_q     <= '0;
			sec_q     <= '0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) twelve_q <= cfg_wr_data;
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				hour_q    <= hour_n;
				min_q     <= min_n;
				sec_q     <= sec_n;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1   <= req_type;
			val_s1   <= set_value;
			alarm_s1 <= alarm_on;
		end
		if (advance) begin
			hours_now   <= hour_n;
			minutes_now <= min_n;
			seconds_now <= sec_n;
			text_left   <= {hh_txt, ":", mm_txt, ":", ss_txt};
			text_right  <= {" ", ampm_txt, " ", "|", "O", alarm_txt};
		end
	end

endmodule

// ----- src/tod_checker.sv -----
// tod_checker: port-level checks on time_of_day_clock_display, bound to the top level
// depends on tod_pkg and the top level's ports only
module tod_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [tod_pkg::HourW-1:0]  hours_now,
	input logic [tod_pkg::UnitW-1:0]  minutes_now,
	input logic [tod_pkg::UnitW-1:0]  seconds_now,
	input logic [63:0]                text_left,
	input logic [63:0]                text_right
);
	import tod_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(text_left) && $stable(hours_now))
		else $error("stalled result beat changed");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hours_now <= HOUR_MAX && minutes_now <= UNIT_MAX
			&& seconds_now <= UNIT_MAX)
		else $error("time out of range");

	a_text_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> text_left[47:40] == ":" && text_left[23:16] == ":"
			&& text_right[31:24] == "|" && text_right[23:16] == "O")
		else $error("display frame characters wrong");

	a_seconds_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> text_left[15:0] == two_digits(seconds_now))
		else $error("seconds text does not match seconds_now");

endmodule

bind time_of_day_clock_display tod_checker u_tod_checker (.*);
